### rtl/core/seam_vertex_splitter_core_macros.svh
// Assertion macros used by the seam vertex splitter RTL.
`ifndef SEAM_VERTEX_SPLITTER_CORE_MACROS_SVH
`define SEAM_VERTEX_SPLITTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SVS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SVS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/svs_pkg.sv
// Types and constants for the seam vertex splitter.
package svs_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int VERT_W       = 10;
  localparam int IDX_W        = 11;
  localparam int TOTAL_W      = 12;
  localparam int VC_W         = 11;
  localparam int EPOCH_W      = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int PADDR_W      = 2;

  localparam logic [IDX_W-1:0]   IDX_MAX     = {IDX_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = PADDR_W'(0);

  // item kinds
  localparam logic [1:0] KIND_CLASSIFY = 2'd0;
  localparam logic [1:0] KIND_INDEX    = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;

  // side codes
  localparam logic [1:0] SIDE_FRONT  = 2'd0;
  localparam logic [1:0] SIDE_BACK   = 2'd1;
  localparam logic [1:0] SIDE_SPLIT  = 2'd2;
  localparam logic [1:0] SIDE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [VERT_W-1:0] vertex_index;
    logic              faces_front;
    logic              on_seam;
    logic              final_corner;
  } svs_in_t;

  typedef struct packed {
    logic               split_made;
    logic [VERT_W-1:0]  split_source;
    logic [IDX_W-1:0]   out_index;
    logic [1:0]         vertex_side;
    logic [IDX_W-1:0]   split_total;
    logic [TOTAL_W-1:0] total_vertices;
    logic [IDX_W-1:0]   lowest_index;
    logic [IDX_W-1:0]   highest_index;
    logic               pass_done;
  } svs_out_t;

  // one side-table word; tag zero never matches a live epoch
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [1:0]         side;
    logic [IDX_W-1:0]   dup;
  } svs_entry_t;

  localparam int ENTRY_W = $bits(svs_entry_t);

endpackage

### rtl/core/svs_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
module svs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/svs_cfg.sv
// APB register file: vertex_count.
module svs_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [svs_pkg::PADDR_W-1:0]    paddr,
  input  logic [svs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [svs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [svs_pkg::VC_W-1:0]       vertex_count
);
  import svs_pkg::*;

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == ADDR_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (wr_hit) begin
      vertex_count <= pwdata[VC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_VERTEX_COUNT) begin
      prdata = {{(CFG_DATA_W-VC_W){1'b0}}, vertex_count};
    end
  end

endmodule

### rtl/core/svs_engine.sv
// Side-table read-modify-write engine: epoch tags, forwarding, wipe pass, result register.
module svs_engine (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  svs_pkg::svs_in_t         item,
  output logic                     done,
  output svs_pkg::svs_out_t        result,
  input  logic [svs_pkg::VC_W-1:0] vertex_count
);
  import svs_pkg::*;

  `include "seam_vertex_splitter_core_macros.svh"

  logic                accept;
  logic                s_valid;
  svs_in_t             s_item;
  logic [EPOCH_W-1:0]  epoch;
  logic [EPOCH_W-1:0]  epoch_next;
  logic [IDX_W-1:0]    split_cnt;
  logic [IDX_W-1:0]    split_next;
  logic [IDX_W-1:0]    min_seen;
  logic [IDX_W-1:0]    min_next;
  logic [IDX_W-1:0]    max_seen;
  logic [IDX_W-1:0]    max_next;
  logic                wipe;
  logic [ADDR_W-1:0]   wipe_addr;
  logic                wipe_start;
  logic                fwd_valid;
  logic [ADDR_W-1:0]   fwd_addr;
  svs_entry_t          fwd_entry;

  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_waddr;
  logic                ram_we;

  svs_entry_t          cur;
  svs_entry_t          wr_entry;
  logic                wr_en;
  logic                hit;
  logic                back_seam;
  logic [1:0]          want;
  logic [IDX_W:0]      dup_sum;
  logic [IDX_W-1:0]    dup;
  logic                made;
  logic [IDX_W-1:0]    idx;
  logic [1:0]          side;
  logic [ADDR_W-1:0]   s_addr;

  // a clear at the last epoch starts a wipe: hold the input off already
  assign busy   = wipe || (s_valid && (s_item.kind == KIND_CLEAR) && (epoch == EPOCH_LAST));
  assign accept = start && !busy;
  assign s_addr = s_item.vertex_index[ADDR_W-1:0];

  svs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_VERTICES)
  ) u_side_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (item.vertex_index[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // forward the word written at the last edge, the RAM returns old data then
  assign cur = (fwd_valid && (fwd_addr == s_addr)) ? fwd_entry : svs_entry_t'(ram_rdata);

  always_comb begin
    hit        = (cur.tag == epoch);
    back_seam  = !s_item.faces_front && s_item.on_seam;
    want       = back_seam ? SIDE_BACK : SIDE_FRONT;
    dup_sum    = {1'b0, vertex_count} + {1'b0, split_cnt};
    dup        = dup_sum[IDX_W] ? IDX_MAX : dup_sum[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_entry   = cur;
    made       = 1'b0;
    idx        = '0;
    side       = hit ? cur.side : SIDE_UNUSED;
    split_next = split_cnt;
    min_next   = min_seen;
    max_next   = max_seen;
    epoch_next = epoch;
    wipe_start = 1'b0;
    if (s_valid) begin
      case (s_item.kind)
        KIND_CLASSIFY: begin
          if (!hit) begin
            wr_en    = 1'b1;
            wr_entry = '{tag: epoch, side: want, dup: cur.dup};
            side     = want;
          end else if ((cur.side != SIDE_SPLIT) && (cur.side != want)) begin
            wr_en    = 1'b1;
            wr_entry = '{tag: epoch, side: SIDE_SPLIT, dup: dup};
            made     = 1'b1;
            idx      = dup;
            side     = SIDE_SPLIT;
            if (split_cnt != IDX_MAX) begin
              split_next = split_cnt + IDX_W'(1);
            end
          end
        end
        KIND_INDEX: begin
          if (back_seam && hit && (cur.side == SIDE_SPLIT)) begin
            idx = cur.dup;
          end else begin
            idx = {1'b0, s_item.vertex_index};
          end
          if (idx < min_seen) begin
            min_next = idx;
          end
          if (idx > max_seen) begin
            max_next = idx;
          end
        end
        KIND_CLEAR: begin
          split_next = '0;
          min_next   = IDX_MAX;
          max_next   = '0;
          side       = SIDE_UNUSED;
          if (epoch == EPOCH_LAST) begin
            wipe_start = 1'b1;
            epoch_next = EPOCH_FIRST;
          end else begin
            epoch_next = epoch + EPOCH_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (wipe) begin
      ram_we    = 1'b1;
      ram_waddr = wipe_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s_valid && wr_en;
      ram_waddr = s_addr;
      ram_wdata = wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      done      <= 1'b0;
      epoch     <= EPOCH_FIRST;
      split_cnt <= '0;
      min_seen  <= IDX_MAX;
      max_seen  <= '0;
      wipe      <= 1'b1;
      wipe_addr <= '0;
      fwd_valid <= 1'b0;
    end else begin
      s_valid   <= accept;
      done      <= s_valid;
      epoch     <= epoch_next;
      split_cnt <= split_next;
      min_seen  <= min_next;
      max_seen  <= max_next;
      fwd_valid <= s_valid && wr_en;
      if (wipe) begin
        wipe_addr <= wipe_addr + ADDR_W'(1);
        if (wipe_addr == ADDR_W'(MAX_VERTICES - 1)) begin
          wipe <= 1'b0;
        end
      end else if (wipe_start) begin
        wipe      <= 1'b1;
        wipe_addr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_item <= item;
    end
    fwd_addr  <= s_addr;
    fwd_entry <= wr_entry;
    if (s_valid) begin
      result.split_made     <= made;
      result.split_source   <= made ? s_item.vertex_index : '0;
      result.out_index      <= idx;
      result.vertex_side    <= side;
      result.split_total    <= split_next;
      result.total_vertices <= {1'b0, vertex_count} + {1'b0, split_next};
      result.lowest_index   <= min_next;
      result.highest_index  <= max_next;
      result.pass_done      <= s_item.final_corner;
    end
  end

  `SVS_ASSERT_IMP(a_beat_latency, clk, rst, accept, ##2 done, "accepted beat lost its result")
  `SVS_ASSERT_IMP(a_wipe_no_item, clk, rst, wipe, !s_valid, "item in flight during wipe pass")
  `SVS_ASSERT_NXT(a_split_mono, clk, rst, s_valid && (s_item.kind != KIND_CLEAR), split_cnt >= $past(split_cnt), "split count dropped without clear")
  `SVS_ASSERT_NXT(a_minmax_order, clk, rst, s_valid && (s_item.kind == KIND_INDEX), min_seen <= max_seen, "min above max after index beat")
  `SVS_ASSERT_IMP(a_made_split, clk, rst, done && result.split_made, result.vertex_side == SIDE_SPLIT, "split reported on non-split vertex")

endmodule

### rtl/core/seam_vertex_splitter_core.sv
// Seam vertex splitter: top level with APB config and corner command port.
//
// One corner beat is taken per clock (start high, busy low). Each beat reads its
// vertex's word from a 1024-entry side-table RAM (registered read) in the accept
// cycle, is resolved and written back in the next, and its result is registered
// at the end of that cycle and sits on result with done high for exactly one
// cycle, in which it is taken. The receiver cannot stall: results must be taken
// as they come. Back-to-back beats on the same vertex see each other's writes
// through a one-entry forward register. Valid bits are epoch tags stored with
// each entry, so a clear beat need not rewrite the table. Every seventh clear,
// when the 3-bit epoch wraps, busy is high in that clear's resolve cycle and then
// for a pass that zeroes the table, one entry per cycle; after reset busy is high
// for the same pass. vertex_count is written through APB (byte address 0); the
// user must write it only while no beat is in flight, which the block itself
// does not enforce. The value at resolve time sets duplicate indexes.
module seam_vertex_splitter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  svs_pkg::svs_in_t               item,
  output logic                           done,
  output svs_pkg::svs_out_t              result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [svs_pkg::PADDR_W-1:0]    paddr,
  input  logic [svs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [svs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import svs_pkg::*;

  logic [VC_W-1:0] vertex_count;

  // register file
  svs_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .vertex_count (vertex_count)
  );

  // side table, counters and result beat
  svs_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .done         (done),
    .result       (result),
    .vertex_count (vertex_count)
  );

endmodule

### dv/svs_corner_checker.sv
// Scoreboard for the seam vertex splitter: predicts every corner beat and checks each result.
module svs_corner_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  svs_pkg::svs_in_t               item,
  input  logic                           done,
  input  svs_pkg::svs_out_t              result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [svs_pkg::PADDR_W-1:0]    paddr,
  input  logic [svs_pkg::CFG_DATA_W-1:0] pwdata,
  output int                             errors,
  output int                             pending,
  output int                             checked,
  output int                             splits
);
  import svs_pkg::*;

  // predictor copy of the side table and model counters
  bit               side_seen [MAX_VERTICES];
  logic [1:0]       side_tag  [MAX_VERTICES];
  logic [IDX_W-1:0] dup_slot  [MAX_VERTICES];
  logic [VC_W-1:0]  vertex_count;
  logic [IDX_W-1:0] split_count;
  logic [IDX_W-1:0] idx_low;
  logic [IDX_W-1:0] idx_high;

  svs_out_t corner_reports_q [$];

  function automatic void start_model();
    foreach (side_seen[i]) side_seen[i] = 1'b0;
    split_count = '0;
    idx_low     = IDX_MAX;
    idx_high    = '0;
  endfunction

  // Applies one corner to the predicted state and returns its report.
  function automatic svs_out_t resolve_corner(svs_in_t c);
    svs_out_t           r;
    int                 v;
    bit                 in_table;
    bit                 back_seam;
    logic [1:0]         want;
    logic [TOTAL_W-1:0] dup;
    r         = '0;
    v         = int'(c.vertex_index);
    in_table  = v < MAX_VERTICES;
    back_seam = !c.faces_front && c.on_seam;
    case (c.kind)
      KIND_CLEAR: begin
        start_model();
      end
      KIND_CLASSIFY: begin
        if (in_table) begin
          want = back_seam ? SIDE_BACK : SIDE_FRONT;
          if (!side_seen[v]) begin
            side_seen[v] = 1'b1;
            side_tag[v]  = want;
          end else if (side_tag[v] != SIDE_SPLIT && side_tag[v] != want) begin
            dup = TOTAL_W'(vertex_count) + TOTAL_W'(split_count);
            if (dup > TOTAL_W'(IDX_MAX)) dup = TOTAL_W'(IDX_MAX);
            side_tag[v] = SIDE_SPLIT;
            dup_slot[v] = dup[IDX_W-1:0];
            if (split_count != IDX_MAX) split_count++;
            r.split_made   = 1'b1;
            r.split_source = c.vertex_index;
            r.out_index    = dup[IDX_W-1:0];
          end
        end
      end
      KIND_INDEX: begin
        r.out_index = IDX_W'(c.vertex_index);
        if (in_table && back_seam && side_seen[v] && side_tag[v] == SIDE_SPLIT)
          r.out_index = dup_slot[v];
        if (r.out_index < idx_low)  idx_low  = r.out_index;
        if (r.out_index > idx_high) idx_high = r.out_index;
      end
      default: ;  // unused kind: status only
    endcase
    r.vertex_side    = (in_table && side_seen[v]) ? side_tag[v] : SIDE_UNUSED;
    r.split_total    = split_count;
    r.total_vertices = TOTAL_W'(vertex_count) + TOTAL_W'(split_count);
    r.lowest_index   = idx_low;
    r.highest_index  = idx_high;
    r.pass_done      = c.final_corner;
    return r;
  endfunction

  task automatic check_field(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    svs_out_t want;
    if (rst) begin
      foreach (side_tag[i]) begin
        side_tag[i] = SIDE_FRONT;
        dup_slot[i] = '0;
      end
      start_model();
      vertex_count = '0;
      corner_reports_q.delete();
      errors  = 0;
      checked = 0;
      splits  = 0;
    end else begin
      if (done) begin
        if (corner_reports_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: expected none, actual %h",
                   $time, result);
        end else begin
          want = corner_reports_q.pop_front();
          check_field("split_made",     want.split_made,     result.split_made);
          check_field("split_source",   want.split_source,   result.split_source);
          check_field("out_index",      want.out_index,      result.out_index);
          check_field("vertex_side",    want.vertex_side,    result.vertex_side);
          check_field("split_total",    want.split_total,    result.split_total);
          check_field("total_vertices", want.total_vertices, result.total_vertices);
          check_field("lowest_index",   want.lowest_index,   result.lowest_index);
          check_field("highest_index",  want.highest_index,  result.highest_index);
          check_field("pass_done",      want.pass_done,      result.pass_done);
          checked++;
          if (want.split_made) splits++;
        end
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_VERTEX_COUNT)
        vertex_count = pwdata[VC_W-1:0];
      if (start && !busy)
        corner_reports_q.push_back(resolve_corner(item));
    end
    pending = corner_reports_q.size();
  end

endmodule

### dv/tb_seam_vertex_splitter_core.sv
// Testbench top for seam_vertex_splitter_core: corner stimulus, APB setup, watchdog and verdict.
module tb_seam_vertex_splitter_core;
  import svs_pkg::*;

  // kind 3 has no name in the package; the block must treat it as status only
  localparam logic [1:0] KIND_NOP = 2'd3;

  // Worst quiet stretch in a correct run is a table wipe (after reset and on
  // every epoch wrap) plus the longest stimulus gap and the pipe; IDLE_LIMIT
  // leaves plenty of margin.
  localparam int IDLE_LIMIT = 5000;
  localparam int BEAT_GOAL  = 1900;
  localparam int SWEEP_N    = 8;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  svs_in_t               item;
  logic                  done;
  svs_out_t              result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int errors;
  int pending;
  int checked;
  int splits;

  int beats_sent;
  int clears_sent;
  int settings_done;

  seam_vertex_splitter_core u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  svs_corner_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending),
    .checked (checked),
    .splits  (splits)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic svs_in_t corner(logic [1:0] kind, int vert, bit front, bit seam, bit last);
    svs_in_t c;
    c.kind         = kind;
    c.vertex_index = VERT_W'(vert);
    c.faces_front  = front;
    c.on_seam      = seam;
    c.final_corner = last;
    return c;
  endfunction

  // Noise beat: any kind, including the unused one, on any vertex.
  function automatic svs_in_t random_corner();
    return corner(2'($urandom_range(0, 3)), $urandom_range(0, MAX_VERTICES - 1),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
  endfunction

  // Drive one corner beat. Entered right after an accept edge (or from idle);
  // changes happen at the falling edge. With no gap, start simply stays high and
  // only the payload moves, so start never sees two updates in one step.
  task automatic push_corner(svs_in_t c, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item  <= c;
    // accept edge: start high and busy low (busy may hold through a table wipe)
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    if (c.kind == KIND_CLEAR) clears_sent++;
  endtask

  // APB write of vertex_count, only once the block is drained and not busy.
  // Upper pwdata bits carry junk; only the low VC_W bits are the register.
  task automatic write_vertex_count(logic [VC_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_VERTEX_COUNT;
    pwdata  <= {21'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;   // access phase; write lands at the next rising edge
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_done++;
  endtask

  // One model: clear, a classify pass over a few triangles drawn from a small
  // vertex window (so vertices collide and split), then the index pass over the
  // same corners. Seam membership is mostly stable per vertex with rare flips.
  // Now and then a noise beat lands mid-pass, or the classify pass is cut short.
  task automatic run_model();
    svs_in_t corners [$];
    svs_in_t c;
    bit      seam_of [64];
    bit      burst;
    bit      front;
    int      span;
    int      base;
    int      tris;
    int      off;
    int      cut;
    burst = ($urandom_range(0, 3) == 0);
    span  = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
    base  = $urandom_range(0, MAX_VERTICES - span);
    tris  = $urandom_range(1, 10);
    foreach (seam_of[i]) seam_of[i] = ($urandom_range(0, 2) == 0);
    for (int t = 0; t < tris; t++) begin
      front = 1'($urandom_range(0, 1));
      for (int k = 0; k < 3; k++) begin
        off = $urandom_range(0, span - 1);
        corners.push_back(corner(KIND_CLASSIFY, base + off, front,
                                 seam_of[off] ^ ($urandom_range(0, 15) == 0), 1'b0));
      end
    end
    corners[corners.size() - 1].final_corner = 1'b1;
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, corners.size() - 1) : corners.size();

    push_corner(corner(KIND_CLEAR, $urandom_range(0, MAX_VERTICES - 1),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0), burst);
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 23) == 0) push_corner(random_corner(), burst);
      push_corner(corners[i], burst);
    end
    foreach (corners[i]) begin
      c      = corners[i];
      c.kind = KIND_INDEX;
      if ($urandom_range(0, 23) == 0) push_corner(random_corner(), burst);
      push_corner(c, burst);
    end
  endtask

  // Watchdog: any stretch with neither an accepted corner nor a result beat
  // that runs past IDLE_LIMIT ends the run.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) idle = 0;
      else idle++;
    end
    $display("Watchdog: no beat for %0d cycles at %0t", IDLE_LIMIT, $time);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [VC_W-1:0] sweep [SWEEP_N];
    rst           = 1'b1;
    start         = 1'b0;
    item          = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    beats_sent    = 0;
    clears_sent   = 0;
    settings_done = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at vertex_count 2047, so the first duplicate index sits at
    // the ceiling and the second one saturates instead of wrapping.
    write_vertex_count(11'd2047);
    // back-to-back on one vertex: front, then back-seam splits it
    push_corner(corner(KIND_CLASSIFY, 0, 1'b1, 1'b0, 1'b0), 1'b1);
    push_corner(corner(KIND_CLASSIFY, 0, 1'b0, 1'b1, 1'b0), 1'b1);
    // already split: neither side re-splits
    push_corner(corner(KIND_CLASSIFY, 0, 1'b0, 1'b1, 1'b0), 1'b1);
    push_corner(corner(KIND_CLASSIFY, 0, 1'b1, 1'b1, 1'b0), 1'b1);
    // back-seam first, repeated, then a front-style use splits (saturated index)
    push_corner(corner(KIND_CLASSIFY, 1023, 1'b0, 1'b1, 1'b0), 1'b1);
    push_corner(corner(KIND_CLASSIFY, 1023, 1'b0, 1'b1, 1'b0), 1'b1);
    push_corner(corner(KIND_CLASSIFY, 1023, 1'b0, 1'b0, 1'b0), 1'b1);
    // front-facing on the seam counts as front; alternating vertex bit patterns
    push_corner(corner(KIND_CLASSIFY, 682, 1'b1, 1'b1, 1'b1), 1'b1);
    push_corner(corner(KIND_CLASSIFY, 341, 1'b0, 1'b0, 1'b0), 1'b0);
    // index pass: remap only back-seam corners on split vertices
    push_corner(corner(KIND_INDEX, 0, 1'b0, 1'b1, 1'b0), 1'b0);
    push_corner(corner(KIND_INDEX, 0, 1'b1, 1'b1, 1'b0), 1'b0);
    push_corner(corner(KIND_INDEX, 1023, 1'b0, 1'b1, 1'b0), 1'b0);
    push_corner(corner(KIND_INDEX, 1023, 1'b0, 1'b0, 1'b0), 1'b0);
    push_corner(corner(KIND_INDEX, 682, 1'b0, 1'b1, 1'b0), 1'b0);
    // unused vertex passes through and reports side unused
    push_corner(corner(KIND_INDEX, 5, 1'b0, 1'b1, 1'b0), 1'b0);
    push_corner(corner(KIND_INDEX, 341, 1'b1, 1'b0, 1'b1), 1'b0);
    // unused kind with every other bit set: status only
    push_corner(corner(KIND_NOP, 1023, 1'b1, 1'b1, 1'b1), 1'b0);
    // clear, then the old split must be gone
    push_corner(corner(KIND_CLEAR, 0, 1'b0, 1'b0, 1'b0), 1'b0);
    push_corner(corner(KIND_INDEX, 0, 1'b0, 1'b1, 1'b0), 1'b1);
    push_corner(corner(KIND_CLASSIFY, 0, 1'b0, 1'b1, 1'b0), 1'b1);
    push_corner(corner(KIND_CLEAR, 1023, 1'b1, 1'b1, 1'b1), 1'b1);

    // Register sweep: both ends of the range plus a few in between.
    sweep[0] = 11'd1024;
    sweep[1] = 11'd0;
    sweep[2] = 11'd1;
    sweep[3] = 11'd3;
    sweep[4] = 11'd1023;
    sweep[5] = 11'($urandom_range(0, 1024));
    sweep[6] = 11'($urandom_range(0, 2047));
    sweep[7] = 11'd640;
    for (int p = 0; p < SWEEP_N; p++) begin
      write_vertex_count(sweep[p]);
      while (beats_sent < BEAT_GOAL * (p + 1) / SWEEP_N) run_model();
    end

    // Drain: drop start, wait for the last result, then a few extra cycles to
    // catch any stray result beat.
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Coverage: %0d corner beats (%0d clears) across %0d vertex_count settings.",
             beats_sent, clears_sent, settings_done);
    $display("Coverage: %0d result beats compared, %0d duplicate vertices reported.",
             checked, splits);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
